FILE: rtl/afrf_pkg.sv
// Shared types and constants of the audio frame ring FIFO.
// No dependencies; imported by audio_frame_ring_fifo_unit.
package afrf_pkg;

	// Fixed field widths of the item and result words
	localparam int unsigned SAMPLE_W   = 32;
	localparam int unsigned LANES      = 4;
	localparam int unsigned CMD_W      = 2;
	localparam int unsigned CHAN_W     = 3;
	localparam int unsigned FILL_OUT_W = 11;
	localparam int unsigned COUNT_W    = 32;

	localparam logic [CHAN_W-1:0] CHAN_RESET = 3'd2;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [COUNT_W-1:0]  count_t;

	// Item commands; the fourth code is unused and ignored
	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

endpackage

FILE: rtl/audio_frame_ring_fifo_unit.sv
// Audio frame ring FIFO: frame store memory, request grant tracking and
// saturating overrun/underrun counters. Depends on afrf_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word per item: cmd,
//   sample_in_0..3 and last_of_request. Write words store a frame, read words
//   return one, clear words reset positions and counters (the store is kept).
//   Output channel (out_valid / out_stall) returns exactly one result word per
//   input word: sample_out_0..3, accepted, fill_frames and the two counters.
//   The channels register (cfg_wen / cfg_wdata) sets the lanes in use; write it
//   only while no word is in flight.
// Result timing and throughput:
//   A result is shown in the cycle after its input word is taken. One word per
//   cycle is sustained while out_stall is low: the frame store is a single
//   memory with one write and one registered read port, and the next word is
//   taken in the same cycle the pending result is taken.
// Reset and stall:
//   arst_n clears positions, fill level, grants and counters; channels returns
//   to 2. Frame store contents are not cleared and need no clearing pass.
//   While out_stall holds a pending result, in_stall is raised and the result
//   and all state hold.
module audio_frame_ring_fifo_unit #(
	parameter int unsigned FRAME_DEPTH  = 1024,
	parameter int unsigned MAX_CHANNELS = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_wen,
	input  logic [afrf_pkg::CHAN_W-1:0]          cfg_wdata,
	// input words
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [afrf_pkg::CMD_W-1:0]           cmd,
	input  logic [afrf_pkg::SAMPLE_W-1:0]        sample_in_0,
	input  logic [afrf_pkg::SAMPLE_W-1:0]        sample_in_1,
	input  logic [afrf_pkg::SAMPLE_W-1:0]        sample_in_2,
	input  logic [afrf_pkg::SAMPLE_W-1:0]        sample_in_3,
	input  logic                                 last_of_request,
	// result words
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [afrf_pkg::SAMPLE_W-1:0]        sample_out_0,
	output logic [afrf_pkg::SAMPLE_W-1:0]        sample_out_1,
	output logic [afrf_pkg::SAMPLE_W-1:0]        sample_out_2,
	output logic [afrf_pkg::SAMPLE_W-1:0]        sample_out_3,
	output logic                                 accepted,
	output logic [afrf_pkg::FILL_OUT_W-1:0]      fill_frames,
	output logic [afrf_pkg::COUNT_W-1:0]         overrun_total,
	output logic [afrf_pkg::COUNT_W-1:0]         underrun_total
);
	import afrf_pkg::*;

	localparam int unsigned IW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
	localparam int unsigned FW = $clog2(FRAME_DEPTH + 1);
	localparam int unsigned MW = MAX_CHANNELS * SAMPLE_W;
	localparam logic [FW-1:0] CAP_F  = FW'(FRAME_DEPTH);
	localparam logic [IW-1:0] LAST_I = IW'(FRAME_DEPTH - 1);

	// control state
	logic [CHAN_W-1:0] channels_q;
	logic [IW-1:0]     widx_q, ridx_q;
	logic [FW-1:0]     fill_q;
	logic [FW-1:0]     wgrant_q, rgrant_q;
	logic              wopen_q, wref_q, ropen_q, rref_q;
	count_t            ovr_q, und_q;

	logic [IW-1:0]     widx_d, ridx_d;
	logic [FW-1:0]     fill_d, wgrant_d, rgrant_d;
	logic              wopen_d, wref_d, ropen_d, rref_d;
	count_t            ovr_d, und_d;
	logic              mem_we, mem_re, acc_d;

	// result stage
	logic              valid_s1, acc_s1, rdsel_s1;
	logic [LANES-1:0]  mask_s1;
	logic [MW-1:0]     rdata_s1;

	logic [MW-1:0]     mem [FRAME_DEPTH];
	logic [MW-1:0]     wdata;
	sample_t           sin [LANES];
	sample_t           sout [LANES];
	logic [LANES-1:0]  mask_d;
	logic              take;
	logic              lanes_on;
	cmd_t              cmd_c;
	logic [FW-1:0]     grant;
	logic              refused;
	logic [FW+FILL_OUT_W-1:0] fill_wide;

	assign take     = in_valid && !in_stall;
	assign in_stall = valid_s1 && out_stall;
	assign lanes_on = (channels_q != '0);
	assign cmd_c    = cmd_t'(cmd);

	assign sin[0] = sample_in_0;
	assign sin[1] = sample_in_1;
	assign sin[2] = sample_in_2;
	assign sin[3] = sample_in_3;

	// Pack the write word: lanes beyond the input ports store zero
	for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_wlane
		if (c < LANES) begin : g_in
			assign wdata[c*SAMPLE_W +: SAMPLE_W] = sin[c];
		end else begin : g_zero
			assign wdata[c*SAMPLE_W +: SAMPLE_W] = '0;
		end
	end

	// Lane mask: lanes below channels and below MAX_CHANNELS read back
	for (genvar c = 0; c < LANES; c++) begin : g_mask
		assign mask_d[c] = (CHAN_W'(c) < channels_q) && (c < MAX_CHANNELS);
	end

	// Next-state logic for positions, grants and counters
	always_comb begin
		widx_d   = widx_q;
		ridx_d   = ridx_q;
		fill_d   = fill_q;
		wgrant_d = wgrant_q;
		rgrant_d = rgrant_q;
		wopen_d  = wopen_q;
		wref_d   = wref_q;
		ropen_d  = ropen_q;
		rref_d   = rref_q;
		ovr_d    = ovr_q;
		und_d    = und_q;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		acc_d    = 1'b0;
		grant    = '0;
		refused  = 1'b0;
		unique case (cmd_c)
			CMD_CLEAR: begin
				widx_d   = '0;
				ridx_d   = '0;
				fill_d   = '0;
				ovr_d    = '0;
				und_d    = '0;
				wgrant_d = '0;
				rgrant_d = '0;
				wopen_d  = 1'b0;
				wref_d   = 1'b0;
				ropen_d  = 1'b0;
				rref_d   = 1'b0;
			end
			CMD_WRITE: begin
				if (lanes_on) begin
					// capture free space at the first word of a request
					grant   = wopen_q ? wgrant_q : (CAP_F - fill_q);
					refused = wopen_q ? wref_q : 1'b0;
					if ((grant != '0) && (fill_q < CAP_F)) begin
						mem_we = 1'b1;
						acc_d  = 1'b1;
						widx_d = (widx_q == LAST_I) ? '0 : widx_q + IW'(1);
						fill_d = fill_q + FW'(1);
						grant  = grant - FW'(1);
					end else begin
						refused = 1'b1;
					end
					if (last_of_request) begin
						if (refused && (ovr_q != '1))
							ovr_d = ovr_q + COUNT_W'(1);
						wopen_d  = 1'b0;
						wref_d   = 1'b0;
						wgrant_d = '0;
					end else begin
						wopen_d  = 1'b1;
						wref_d   = refused;
						wgrant_d = grant;
					end
				end
			end
			CMD_READ: begin
				if (lanes_on) begin
					// capture fill level at the first word of a request
					grant   = ropen_q ? rgrant_q : fill_q;
					refused = ropen_q ? rref_q : 1'b0;
					if ((grant != '0) && (fill_q != '0)) begin
						mem_re = 1'b1;
						acc_d  = 1'b1;
						ridx_d = (ridx_q == LAST_I) ? '0 : ridx_q + IW'(1);
						fill_d = fill_q - FW'(1);
						grant  = grant - FW'(1);
					end else begin
						refused = 1'b1;
					end
					if (last_of_request) begin
						if (refused && (und_q != '1))
							und_d = und_q + COUNT_W'(1);
						ropen_d  = 1'b0;
						rref_d   = 1'b0;
						rgrant_d = '0;
					end else begin
						ropen_d  = 1'b1;
						rref_d   = refused;
						rgrant_d = grant;
					end
				end
			end
			default: begin
				// unused command: no change
			end
		endcase
	end

	// Hold control state; advance only on a taken word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channels_q <= CHAN_RESET;
			widx_q     <= '0;
			ridx_q     <= '0;
			fill_q     <= '0;
			wgrant_q   <= '0;
			rgrant_q   <= '0;
			wopen_q    <= 1'b0;
			wref_q     <= 1'b0;
			ropen_q    <= 1'b0;
			rref_q     <= 1'b0;
			ovr_q      <= '0;
			und_q      <= '0;
			valid_s1   <= 1'b0;
			acc_s1     <= 1'b0;
			rdsel_s1   <= 1'b0;
			mask_s1    <= '0;
		end else begin
			if (cfg_wen)
				channels_q <= cfg_wdata;
			if (take) begin
				widx_q   <= widx_d;
				ridx_q   <= ridx_d;
				fill_q   <= fill_d;
				wgrant_q <= wgrant_d;
				rgrant_q <= rgrant_d;
				wopen_q  <= wopen_d;
				wref_q   <= wref_d;
				ropen_q  <= ropen_d;
				rref_q   <= rref_d;
				ovr_q    <= ovr_d;
				und_q    <= und_d;
				valid_s1 <= 1'b1;
				acc_s1   <= acc_d;
				rdsel_s1 <= mem_re;
				mask_s1  <= mask_d;
			end else if (!out_stall) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Frame store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (take && mem_we)
			mem[widx_q] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (take && mem_re)
			rdata_s1 <= mem[ridx_q];
	end

	// Drop lanes that are masked off or not read
	for (genvar c = 0; c < LANES; c++) begin : g_olane
		if (c < MAX_CHANNELS) begin : g_mem
			assign sout[c] = (rdsel_s1 && mask_s1[c]) ?
				rdata_s1[c*SAMPLE_W +: SAMPLE_W] : '0;
		end else begin : g_zero
			assign sout[c] = '0;
		end
	end

	assign fill_wide = {{FILL_OUT_W{1'b0}}, fill_q};

	assign out_valid      = valid_s1;
	assign sample_out_0   = sout[0];
	assign sample_out_1   = sout[1];
	assign sample_out_2   = sout[2];
	assign sample_out_3   = sout[3];
	assign accepted       = acc_s1;
	assign fill_frames    = fill_wide[FILL_OUT_W-1:0];
	assign overrun_total  = ovr_q;
	assign underrun_total = und_q;

	// Fill level never exceeds the store depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CAP_F)
		else $error("fill level above capacity");

	// Every taken word yields a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid)
		else $error("taken word produced no result");

	// State holds while no word is taken
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> ($stable(fill_q) && $stable(widx_q) && $stable(ridx_q)))
		else $error("state moved without a taken word");

	// A result that is not accepted carries zero samples on lanes 0 and 1
	a_zero_samples: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !accepted) |-> (sample_out_0 == '0 && sample_out_1 == '0))
		else $error("refused result carries sample data");

	// A grant is never held by a closed request
	a_grant_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(wopen_q || (wgrant_q == '0)) && (ropen_q || (rgrant_q == '0)))
		else $error("grant left on a closed request");

endmodule
